// ----- hw/rtl/ptex_pkg.sv -----
// ---------------------------------------------------------------------------
// Procedural texture package
// Shared types and fixed constants for the procedural texture albedo unit.
// ---------------------------------------------------------------------------
package ptex_pkg;

  // Texture mode codes. Codes above MODE_WAVE produce black.
  typedef enum logic [2:0] {
    MODE_SOLID   = 3'd0,
    MODE_CHK_XYZ = 3'd1,
    MODE_CHK_UV  = 3'd2,
    MODE_WAVE    = 3'd3
  } ptex_mode_t;

  // Per-transaction fields that travel beside the lanes to the merge stage.
  typedef struct packed {
    ptex_mode_t  mode;
    logic [23:0] color_a;
    logic [23:0] color_b;
  } ptex_side_t;

  // 1/(2*pi) in Q32, fits in 30 bits.
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  // pi/2 in Q30, used only when the sine table is elaborated.
  localparam logic [63:0] PI_HALF_Q30    = 64'd1686629713;

  localparam int SINE_W   = 17;  // table entry, 0..32768
  localparam int SIN_W    = 18;  // signed sine, -32768..32768
  localparam int F_UV     = 24;  // fraction bits of density*u or density*v
  localparam int LANE_LAT = 8;   // register stages inside one lane

  localparam logic [SIN_W-1:0] ONE_Q15 = 18'd32768;

endpackage

// ----- hw/rtl/ptex_sine_rom.sv -----
// ---------------------------------------------------------------------------
// Quarter-wave sine ROM
// Constant table of sin(pi/2*i/ENTRIES) in Q15, registered read port.
// ---------------------------------------------------------------------------
module ptex_sine_rom #(
  parameter int ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic [$clog2(ENTRIES+1)-1:0]     addr,
  output logic [ptex_pkg::SINE_W-1:0]      rdata
);
  import ptex_pkg::*;

  localparam logic [63:0] DIVS [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                       64'd110, 64'd156, 64'd210, 64'd272};

  // Nine-term Taylor series in Q30, rounded to Q15 and clamped to [0, 1.0].
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [3:0]         k;
    x    = (PI_HALF_Q30 * 64'(i)) / ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (k = 4'd1; k <= 4'd8; k++) begin
      term = ((term * x2) >> 30) / DIVS[3'(k - 4'd1)];
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) begin
      sum = 64'sd32768;
    end
    return sum[SINE_W-1:0];
  endfunction

  logic [SINE_W-1:0] tab_w [ENTRIES+1];

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_tab
    assign tab_w[g] = sine_entry(g);
  end

  always_ff @(posedge clk) begin
    rdata <= tab_w[addr];
  end

endmodule

// ----- hw/rtl/ptex_lane.sv -----
// ---------------------------------------------------------------------------
// Sine lane
// Turns density times one coordinate into a Q15 sine through an
// eight-stage pipeline: magnitude, product, phase, quadrant and table lookup.
// ---------------------------------------------------------------------------
module ptex_lane #(
  parameter int SINE_ENTRIES    = 1024,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic [31:0]                         coord,
  input  logic                                uv_sel,
  input  logic [15:0]                         density,
  output logic signed [ptex_pkg::SIN_W-1:0]   sine
);
  import ptex_pkg::*;

  localparam int F_PT   = 8 + COORD_FRAC_BITS;
  localparam int ADDR_W = $clog2(SINE_ENTRIES + 1);
  localparam logic [ADDR_W-1:0] N_ENT = ADDR_W'(SINE_ENTRIES);

  logic [31:0]             mag_r;
  logic                    neg1_r, uv1_r;
  logic [15:0]             dens1_r;
  logic [47:0]             m_r;
  logic                    neg2_r, uv2_r;
  logic [53:0]             plo_r, phi_r;
  logic                    neg3_r, uv3_r;
  logic [63:0]             sum_w;
  logic [31:0]             ph_r;
  logic                    neg4_r;
  logic [31:0]             phn_r;
  logic [30+ADDR_W-1:0]    frac_prod_w;
  logic [ADDR_W-1:0]       idx_r;
  logic [1:0]              q6_r, q7_r;
  logic [ADDR_W-1:0]       addr_w;
  logic [SINE_W-1:0]       val_w;
  logic signed [SIN_W-1:0] sine_r;

  // The full product m*INV is cut into two partial products at bit 24.
  assign sum_w = {phi_r[39:0], 24'b0} + {10'b0, plo_r};

  assign frac_prod_w = (30+ADDR_W)'(phn_r[29:0]) * (30+ADDR_W)'(N_ENT);

  assign addr_w = q6_r[0] ? (N_ENT - idx_r) : idx_r;

  always_ff @(posedge clk) begin
    mag_r   <= coord[31] ? (32'd0 - coord) : coord;
    neg1_r  <= coord[31];
    uv1_r   <= uv_sel;
    dens1_r <= density;

    m_r    <= 48'(dens1_r) * 48'(mag_r);
    neg2_r <= neg1_r;
    uv2_r  <= uv1_r;

    plo_r  <= 54'(m_r[23:0]) * 54'(INV_TWO_PI_Q32);
    phi_r  <= 54'(m_r[47:24]) * 54'(INV_TWO_PI_Q32);
    neg3_r <= neg2_r;
    uv3_r  <= uv2_r;

    ph_r   <= uv3_r ? sum_w[F_UV+31 -: 32] : sum_w[F_PT+31 -: 32];
    neg4_r <= neg3_r;

    phn_r <= neg4_r ? (32'd0 - ph_r) : ph_r;

    idx_r <= frac_prod_w[30 +: ADDR_W];
    q6_r  <= phn_r[31:30];

    q7_r <= q6_r;

    sine_r <= q7_r[1] ? (SIN_W'(0) - SIN_W'(val_w)) : SIN_W'(val_w);
  end

  ptex_sine_rom #(
    .ENTRIES (SINE_ENTRIES)
  ) u_rom (
    .clk   (clk),
    .addr  (addr_w),
    .rdata (val_w)
  );

  assign sine = sine_r;

endmodule

// ----- hw/rtl/ptex_merge.sv -----
// ---------------------------------------------------------------------------
// Merge stage
// Combines the lane sines with the mode and colors into the registered
// albedo result.
// ---------------------------------------------------------------------------
module ptex_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid,
  input  ptex_pkg::ptex_side_t               side,
  input  logic signed [ptex_pkg::SIN_W-1:0]  sine [3],
  output logic                               out_valid,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue
);
  import ptex_pkg::*;

  logic              valid_r;
  logic [23:0]       col_r, col_nxt;
  logic [2:0]        zero_w, neg_w;
  logic [16:0]       lift_w [3];
  logic [24:0]       wave_w [3];

  for (genvar g = 0; g < 3; g++) begin : g_chan
    assign zero_w[g] = (sine[g] == '0);
    assign neg_w[g]  = sine[g][SIN_W-1];
    // (s + 1.0) lies in [0, 2.0], so 17 unsigned bits hold it.
    assign lift_w[g] = 17'(sine[g] + signed'(ONE_Q15));
    assign wave_w[g] = 25'(side.color_a[23-8*g -: 8]) * 25'(lift_w[g]);
  end

  always_comb begin
    col_nxt = 24'd0;
    case (side.mode)
      MODE_SOLID: begin
        col_nxt = side.color_a;
      end
      MODE_CHK_XYZ: begin
        col_nxt = (|zero_w || !(^neg_w)) ? side.color_b : side.color_a;
      end
      MODE_CHK_UV: begin
        col_nxt = (|zero_w[1:0] || !(^neg_w[1:0])) ? side.color_b : side.color_a;
      end
      MODE_WAVE: begin
        col_nxt = {wave_w[0][23:16], wave_w[1][23:16], wave_w[2][23:16]};
      end
      default: begin
        col_nxt = 24'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid;
    end
    col_r <= col_nxt;
  end

  assign out_valid = valid_r;
  assign red       = col_r[23:16];
  assign green     = col_r[15:8];
  assign blue      = col_r[7:0];

endmodule

// ----- hw/rtl/procedural_texture_albedo_top.sv -----
// ---------------------------------------------------------------------------
// Procedural texture albedo unit
// Shades one ray hit per clock cycle with a solid, checker or wave texture.
// ---------------------------------------------------------------------------
// The unit takes a new ray hit in every clock cycle and never raises busy, so
// a transaction is accepted at every rising edge with start high. Each
// accepted transaction yields exactly one albedo result, marked by out_valid
// for one cycle; results leave in the order in which hits came in. Each hit
// passes through the eight register stages of the sine lanes (coordinate
// magnitude, density product, two partial products of the phase multiply,
// phase select, sign, table index and the registered sine ROM read, then the
// quadrant sign) and then the output register of the merge stage. Because the
// receiver cannot stall, a result must be taken in the cycle it is presented.
// ---------------------------------------------------------------------------
module procedural_texture_albedo_top #(
  parameter int SINE_ENTRIES    = 1024,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [15:0]        in_surf_u,
  input  logic [15:0]        in_surf_v,
  input  logic [15:0]        in_density,
  input  logic [23:0]        in_color_a,
  input  logic [23:0]        in_color_b,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);
  import ptex_pkg::*;

  localparam int OUT_LAT = LANE_LAT + 1;

  // The pipeline never holds an item back, so the unit is never busy.
  assign busy = 1'b0;

  logic                    accept_w;
  logic                    uv_w;
  logic [31:0]             coord_w [3];
  logic signed [SIN_W-1:0] sine_w  [3];
  ptex_side_t              side_w;
  logic                    v_r    [LANE_LAT];
  ptex_side_t              side_r [LANE_LAT];

  assign accept_w = start && !busy;

  // In the uv checker mode lanes 0 and 1 carry u and v as unsigned Q0.16
  // values; lane 2 keeps z, and the merge stage ignores it in that mode.
  assign uv_w       = (ptex_mode_t'(in_mode) == MODE_CHK_UV);
  assign coord_w[0] = uv_w ? {16'b0, in_surf_u} : in_point_x;
  assign coord_w[1] = uv_w ? {16'b0, in_surf_v} : in_point_y;
  assign coord_w[2] = in_point_z;

  assign side_w.mode    = ptex_mode_t'(in_mode);
  assign side_w.color_a = in_color_a;
  assign side_w.color_b = in_color_b;

  // Three identical sine lanes work on x, y and z (or u and v) side by side.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    ptex_lane #(
      .SINE_ENTRIES    (SINE_ENTRIES),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .coord   (coord_w[g]),
      .uv_sel  (uv_w),
      .density (in_density),
      .sine    (sine_w[g])
    );
  end

  // The valid bit and the mode and colors ride along a delay line that is
  // exactly as deep as a lane, so they meet the sines at the merge stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= accept_w;
      for (int i = 1; i < LANE_LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
    side_r[0] <= side_w;
    for (int i = 1; i < LANE_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  ptex_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (v_r[LANE_LAT-1]),
    .side      (side_r[LANE_LAT-1]),
    .sine      (sine_w),
    .out_valid (out_valid),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

`ifndef SYNTHESIS
  // Every result traces back to a transaction accepted a fixed time earlier.
  a_result_has_source : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, OUT_LAT))
    else $error("result without a matching accepted transaction");

  // Every accepted transaction produces a result after the pipeline latency.
  a_source_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##OUT_LAT out_valid)
    else $error("accepted transaction produced no result");

  // Solid mode passes color A through untouched.
  a_solid_passes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_mode, OUT_LAT) == MODE_SOLID) |->
      ({out_red, out_green, out_blue} == $past(in_color_a, OUT_LAT)))
    else $error("solid mode result differs from color A");

  // Modes beyond the wave mode give black.
  a_unknown_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_mode, OUT_LAT) > MODE_WAVE) |->
      ({out_red, out_green, out_blue} == 24'd0))
    else $error("unknown mode result is not black");
`endif

endmodule
